// ----- design/mvmar_pkg.sv -----
`default_nettype none

package mvmar_pkg;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 7;
    localparam int DIM_W  = 8;
    localparam int MAT_W  = 16;
    localparam int VEC_W  = 24;
    localparam int PROD_W = MAT_W + VEC_W;
    localparam int ACC_W  = 48;
    localparam int DIFF_W = ACC_W + 1;
    localparam int RES_W  = 47;

    localparam logic [DIM_W-1:0]  DIM_RESET = 8'd128;
    localparam logic [DIFF_W-1:0] RES_MAX   = {{(DIFF_W-RES_W){1'b0}}, {RES_W{1'b1}}};

    localparam logic [MODE_W-1:0] MODE_MATRIX    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REFERENCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANDIDATE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic wr_mat;
        logic wr_vec;
        logic clear_best;
        logic issue;
        logic first_col;
        logic last_col;
        logic eval;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- design/matvec_max_abs_residual_top.sv -----
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_mode, i_row, i_column, i_matrix_value,
//                                                  i_vector_value, i_last
// result    out        o_out_valid / i_out_ready   o_max_residual
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_dimensions
//
// Matrix writes and vector elements without last leave the block idle, so input stays ready.
// A last vector element sweeps the n*n active entries (n = active dimensions) through one
// multiply-accumulate unit, one entry per cycle, then the pipeline drains: input is held off
// until the drain ends, after a last candidate element also until the result is loaded.
// Reset (synchronous, active low) sets dimensions to 128; the stores are not cleared.
// A pending result does not stall input; a finished sweep waits only for the result register.

module matvec_max_abs_residual_top
    import mvmar_pkg::*;
#(
    parameter int MAX_DIM = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_column,
    input  wire logic signed [MAT_W-1:0]  i_matrix_value,
    input  wire logic signed [VEC_W-1:0]  i_vector_value,
    input  wire logic                     i_last,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [RES_W-1:0]              o_max_residual,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [DIM_W-1:0]         i_cfg_dimensions
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] row_idx, col_idx;

    assign o_cfg_ready = 1'b1;

    mvmar_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_last           (i_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_dimensions (i_cfg_dimensions),
        .i_status         (status),
        .o_cmd            (cmd),
        .o_row_idx        (row_idx),
        .o_col_idx        (col_idx)
    );

    mvmar_dp #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row_idx      (row_idx),
        .i_col_idx      (col_idx),
        .i_matrix_value (i_matrix_value),
        .i_vector_value (i_vector_value),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_max_residual (o_max_residual)
    );

endmodule

`default_nettype wire

// ----- design/mvmar_dp.sv -----
`default_nettype none

module mvmar_dp
    import mvmar_pkg::*;
#(
    parameter int MAX_DIM = 128,
    parameter int AW      = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire logic [AW-1:0]            i_row_idx,
    input  wire logic [AW-1:0]            i_col_idx,
    input  wire logic signed [MAT_W-1:0]  i_matrix_value,
    input  wire logic signed [VEC_W-1:0]  i_vector_value,
    input  wire logic                     i_out_ready,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output logic [RES_W-1:0]              o_max_residual
);

    localparam int MAW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    typedef struct packed {
        logic v;
        logic first;
        logic last;
        logic eval;
    } t_tag;

    logic signed [MAT_W-1:0] r_mat_mem [MAX_DIM*MAX_DIM];
    logic signed [VEC_W-1:0] r_vec_mem [MAX_DIM];
    logic signed [ACC_W-1:0] r_off_mem [MAX_DIM];

    logic [MAW-1:0] mat_addr;

    t_tag r_t1, r_t2, r_t3;
    logic r_v4, r_v5;
    logic [AW-1:0] r_row1, r_row2, r_row3;
    logic signed [MAT_W-1:0]  r_mat_q;
    logic signed [VEC_W-1:0]  r_vec_q;
    logic signed [ACC_W-1:0]  r_off1, r_off2, r_off3;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DIFF_W-1:0] r_diff;
    logic [DIFF_W-1:0]        r_abs;
    logic [DIFF_W-1:0]        r_best;
    logic                     r_out_valid;
    logic [RES_W-1:0]         r_out;

    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] n_acc;

    assign mat_addr = MAW'(MAW'(i_row_idx) * MAW'(MAX_DIM) + MAW'(i_col_idx));
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_acc    = r_t2.first ? prod_ext : r_acc + prod_ext;

    // Storage: one write and one registered read per memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mat) begin
            r_mat_mem[mat_addr] <= i_matrix_value;
        end
        if (i_cmd.wr_vec) begin
            r_vec_mem[i_col_idx] <= i_vector_value;
        end
        if (r_t3.v && r_t3.last && !r_t3.eval) begin
            r_off_mem[r_row3] <= r_acc;
        end
        r_mat_q <= r_mat_mem[mat_addr];
        r_vec_q <= r_vec_mem[i_col_idx];
        r_off1  <= r_off_mem[i_row_idx];
    end

    // Multiply, accumulate, subtract, magnitude, running maximum
    always_ff @(posedge i_clk) begin
        r_row1 <= i_row_idx;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
        r_off2 <= r_off1;
        r_off3 <= r_off2;
        r_prod <= r_mat_q * r_vec_q;
        if (r_t2.v) begin
            r_acc <= n_acc;
        end
        r_diff <= {r_acc[ACC_W-1], r_acc} - {r_off3[ACC_W-1], r_off3};
        r_abs  <= r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
        if (i_cmd.load_out) begin
            r_out <= (r_best > RES_MAX) ? RES_MAX[RES_W-1:0] : r_best[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1        <= '0;
            r_t2        <= '0;
            r_t3        <= '0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_t1 <= '{v: i_cmd.issue, first: i_cmd.first_col,
                      last: i_cmd.last_col, eval: i_cmd.eval};
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_v4 <= r_t3.v && r_t3.last && r_t3.eval;
            r_v5 <= r_v4;
            if (i_cmd.clear_best) begin
                r_best <= '0;
            end else if (r_v5 && (r_abs > r_best)) begin
                r_best <= r_abs;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pipe_busy = r_t1.v || r_t2.v || r_t3.v || r_v4 || r_v5;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_max_residual     = r_out;

endmodule

`default_nettype wire

// ----- design/mvmar_ctrl.sv -----
`default_nettype none

module mvmar_ctrl
    import mvmar_pkg::*;
#(
    parameter int MAX_DIM = 128,
    parameter int AW      = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [IDX_W-1:0]  i_row,
    input  wire logic [IDX_W-1:0]  i_column,
    input  wire logic              i_last,
    input  wire logic              i_cfg_valid,
    input  wire logic [DIM_W-1:0]  i_cfg_dimensions,
    input  wire t_status           i_status,
    output t_cmd                   o_cmd,
    output logic [AW-1:0]          o_row_idx,
    output logic [AW-1:0]          o_col_idx
);

    localparam int CW = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    t_state            r_state;
    logic [DIM_W-1:0]  r_dim;
    logic [AW-1:0]     r_row, r_col;
    logic              r_eval;

    logic [CW-1:0] n_act, n_m1;
    logic          accept, row_ok, col_ok, is_vec, col_end, row_end;

    always_comb begin
        if (32'(r_dim) > 32'(MAX_DIM)) begin
            n_act = CW'(MAX_DIM);
        end else begin
            n_act = CW'(r_dim);
        end
    end

    assign n_m1    = n_act - 1'b1;
    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign row_ok  = 32'(i_row) < 32'(MAX_DIM);
    assign col_ok  = 32'(i_column) < 32'(MAX_DIM);
    assign is_vec  = (i_mode == MODE_REFERENCE) || (i_mode == MODE_CANDIDATE);
    assign col_end = CW'(r_col) == n_m1;
    assign row_end = CW'(r_row) == n_m1;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_mat     = accept && (i_mode == MODE_MATRIX) && row_ok && col_ok;
        o_cmd.wr_vec     = accept && is_vec && col_ok;
        o_cmd.clear_best = accept && is_vec && i_last;
        o_cmd.issue      = (r_state == ST_SWEEP);
        o_cmd.first_col  = (r_col == '0);
        o_cmd.last_col   = col_end;
        o_cmd.eval       = r_eval;
        o_cmd.load_out   = (r_state == ST_RESULT) && i_status.out_free;
        if (r_state == ST_IDLE) begin
            o_row_idx = AW'(i_row);
            o_col_idx = AW'(i_column);
        end else begin
            o_row_idx = r_row;
            o_col_idx = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dim   <= DIM_RESET;
            r_row   <= '0;
            r_col   <= '0;
            r_eval  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dim <= i_cfg_dimensions;
            end
            case (r_state)
                ST_IDLE: begin
                    r_row <= '0;
                    r_col <= '0;
                    if (accept && is_vec && i_last) begin
                        r_eval <= (i_mode == MODE_CANDIDATE);
                        if (n_act != '0) begin
                            r_state <= ST_SWEEP;
                        end else if (i_mode == MODE_CANDIDATE) begin
                            r_state <= ST_RESULT;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                        if (row_end) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    // wait for the last row to leave the pipeline
                    if (!i_status.pipe_busy) begin
                        r_state <= r_eval ? ST_RESULT : ST_IDLE;
                    end
                end
                ST_RESULT: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_matvec_max_abs_residual_top.sv -----
`timescale 1ns / 100ps

module tb_matvec_max_abs_residual_top;
    import mvmar_pkg::*;

    localparam int              DIM_MAX      = 128;
    localparam int              N_DIR        = 21;
    localparam int              N_PHASES     = 22;
    localparam int unsigned     CYCLE_LIMIT  = 10_000_000;
    localparam longint unsigned RESIDUAL_TOP = (64'd1 << RES_W) - 64'd1;

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind        kind;
        logic [DIM_W-1:0]  dims;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [MAT_W-1:0]  mval;
        logic [VEC_W-1:0]  vval;
        logic              last;
        logic              fixed;
        logic [RES_W-1:0]  res;
    } t_dir_row;

    // The buffer holds the reference vector when the table starts, with element 0 at the
    // negative extreme, so a candidate that repeats element 0 reproduces it exactly.
    t_dir_row dir_tab [N_DIR] = '{
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd0,   16'h0000, 24'h800000, 1'b1, 1'b1,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd127, 16'h0000, 24'h7FFFFF, 1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_MATRIX,    7'd127, 7'd127, 16'h7FFF, 24'h000000, 1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_MATRIX,    7'd0,   7'd0,   16'h8000, 24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd64,  16'h0000, 24'h000000, 1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_UNUSED,    7'd127, 7'd127, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0,
          47'd0},
        '{STEP_CFG,  8'd0,   MODE_MATRIX,    7'd0,   7'd0,   16'h0000, 24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_REFERENCE, 7'd0,   7'd3,   16'h0000, 24'd123,    1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd3,   16'h0000, 24'd5,      1'b1, 1'b1,
          47'd0},
        '{STEP_CFG,  8'd255, MODE_MATRIX,    7'd0,   7'd0,   16'h0000, 24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd3,   16'h0000, 24'd123,    1'b1, 1'b0,
          47'd0},
        '{STEP_CFG,  8'd1,   MODE_MATRIX,    7'd0,   7'd0,   16'h0000, 24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_MATRIX,    7'd0,   7'd0,   16'd1,    24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_REFERENCE, 7'd0,   7'd0,   16'h0000, 24'd16,     1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd0,   16'h0000, 24'd16,     1'b1, 1'b1,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd0,   16'h0000, 24'h7FFFFF, 1'b1, 1'b1,
          47'd8388591},
        '{STEP_ITEM, 8'd0,   MODE_MATRIX,    7'd0,   7'd0,   16'h8000, 24'h000000, 1'b0, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd0,   16'h0000, 24'h800000, 1'b1, 1'b1,
          47'd274877906928},
        '{STEP_ITEM, 8'd0,   MODE_REFERENCE, 7'd0,   7'd0,   16'h0000, 24'h800000, 1'b1, 1'b0,
          47'd0},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd0,   16'h0000, 24'h7FFFFF, 1'b1, 1'b1,
          47'd549755781120},
        '{STEP_ITEM, 8'd0,   MODE_CANDIDATE, 7'd0,   7'd1,   16'h0000, 24'd7,      1'b1, 1'b0,
          47'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         column;
    logic signed [MAT_W-1:0]  matrix_value;
    logic signed [VEC_W-1:0]  vector_value;
    logic                     last;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [RES_W-1:0]         max_residual;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [DIM_W-1:0]         cfg_dimensions;

    bit                       steady = 1'b0;
    int unsigned              cycles = 0;
    int unsigned              n_bad = 0;

    // Shadow copy of the block's stores and its one register
    logic signed [MAT_W-1:0]  coef [DIM_MAX*DIM_MAX];
    logic signed [VEC_W-1:0]  vbuf [DIM_MAX];
    longint                   offs [DIM_MAX];
    logic [DIM_W-1:0]         dims_q;

    logic [RES_W-1:0]         residual_due [$];

    matvec_max_abs_residual_top #(
        .MAX_DIM(DIM_MAX)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (mode),
        .i_row            (row),
        .i_column         (column),
        .i_matrix_value   (matrix_value),
        .i_vector_value   (vector_value),
        .i_last           (last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_max_residual   (max_residual),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_dimensions (cfg_dimensions)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned active_dims();
        return (dims_q > DIM_MAX) ? DIM_MAX : int'(dims_q);
    endfunction

    function automatic longint row_sum(input int unsigned r, input int unsigned n);
        longint      acc;
        int unsigned j;
        acc = 0;
        for (j = 0; j < n; j++)
            acc += longint'(coef[r * DIM_MAX + j]) * longint'(vbuf[j]);
        return acc;
    endfunction

    // Update the shadow state for one accepted item; return 1 when it yields a residual.
    function automatic bit track_item(input logic [MODE_W-1:0] md,
                                      input logic [IDX_W-1:0] r, c,
                                      input logic [MAT_W-1:0] mv,
                                      input logic [VEC_W-1:0] vv,
                                      input logic lst,
                                      output logic [RES_W-1:0] res);
        int unsigned     n;
        int unsigned     i;
        longint          diff;
        longint unsigned mag;
        longint unsigned best;
        n   = active_dims();
        res = '0;
        if (md == MODE_MATRIX) begin
            coef[{r, c}] = mv;
            return 1'b0;
        end
        if (md == MODE_UNUSED)
            return 1'b0;
        vbuf[c] = vv;
        if (!lst)
            return 1'b0;
        if (md == MODE_REFERENCE) begin
            for (i = 0; i < n; i++)
                offs[i] = row_sum(i, n);
            return 1'b0;
        end
        best = 0;
        for (i = 0; i < n; i++) begin
            diff = row_sum(i, n) - offs[i];
            mag  = (diff < 0) ? longint'(-diff) : diff;
            if (mag > best)
                best = mag;
        end
        if (best > RESIDUAL_TOP)
            best = RESIDUAL_TOP;
        res = best[RES_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] pick_idx(input int unsigned n);
        if (n == 0 || $urandom_range(7) == 0)
            return 7'($urandom_range(DIM_MAX - 1));
        return 7'($urandom_range(n - 1));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] md,
                             input logic [IDX_W-1:0] r, c,
                             input logic [MAT_W-1:0] mv,
                             input logic [VEC_W-1:0] vv,
                             input logic lst,
                             input logic fixed = 1'b0,
                             input logic [RES_W-1:0] fixed_res = '0);
        logic [RES_W-1:0] pred;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= md;
        row          <= r;
        column       <= c;
        matrix_value <= mv;
        vector_value <= vv;
        last         <= lst;
        do @(posedge clk); while (!in_ready);
        if (track_item(md, r, c, mv, vv, lst, pred))
            residual_due.push_back(fixed ? fixed_res : pred);
    endtask

    // Write the register only once every result is out and any sweep has drained.
    task automatic set_dimensions(input logic [DIM_W-1:0] d);
        int unsigned n;
        @(negedge clk);
        in_valid <= 1'b0;
        while (residual_due.size() != 0)
            @(negedge clk);
        n = active_dims();
        repeat (n * n + 16) @(negedge clk);
        cfg_dimensions <= d;
        cfg_valid      <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        dims_q = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stream a vector; full and in order at sizes 1 to 16, one to four random elements otherwise.
    task automatic send_vector(input logic [MODE_W-1:0] md, input int unsigned n,
                               inout int sent);
        int unsigned cnt;
        int unsigned i;
        cnt = (n == 0) ? 1 : (n > 16) ? $urandom_range(1, 4) : n;
        for (i = 0; i < cnt; i++)
            send_item(md, pick_idx(n), (n == 0 || n > 16) ? pick_idx(n) : 7'(i),
                      16'($urandom), 24'($urandom), i == cnt - 1);
        sent += cnt;
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] d);
        int unsigned       n;
        int                budget;
        int                sent;
        int                k;
        logic [MODE_W-1:0] md;
        set_dimensions(d);
        n      = active_dims();
        budget = (n > 16) ? 12 : 34;
        sent   = 0;
        while (sent < budget) begin
            if ($urandom_range(9) < 7) begin
                k = $urandom_range(0, 4);
                repeat (k)
                    send_item(MODE_MATRIX, pick_idx(n), pick_idx(n), 16'($urandom),
                              24'($urandom), $urandom_range(1) == 1);
                sent += k;
                if ($urandom_range(3) != 0)
                    send_vector(MODE_REFERENCE, n, sent);
                repeat ($urandom_range(1, 3))
                    send_vector(MODE_CANDIDATE, n, sent);
            end else begin
                // noise: any mode, any index, early last
                md = 2'($urandom);
                send_item(md, 7'($urandom), 7'($urandom), 16'($urandom), 24'($urandom),
                          $urandom_range(2) == 0);
                if (md != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 20);

    always @(posedge clk) begin
        logic [RES_W-1:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (residual_due.size() == 0) begin
                $display("%0t: unexpected result, actual %0d", $time, max_residual);
                n_bad++;
            end else begin
                want = residual_due.pop_front();
                if (max_residual !== want) begin
                    $display("%0t: max_residual mismatch: expected %0d, actual %0d",
                             $time, want, max_residual);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, residual_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int               i;
        int               p;
        int               r;
        int               c;
        int unsigned      n;
        logic [DIM_W-1:0] d;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_MATRIX;
        row            = '0;
        column         = '0;
        matrix_value   = '0;
        vector_value   = '0;
        last           = 1'b0;
        cfg_valid      = 1'b0;
        cfg_dimensions = DIM_RESET;
        dims_q         = DIM_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every store at full size so no later sweep reads an unwritten entry.
        for (r = 0; r < DIM_MAX; r++)
            for (c = 0; c < DIM_MAX; c++)
                send_item(MODE_MATRIX, 7'(r), 7'(c), 16'($urandom), 24'($urandom),
                          $urandom_range(1) == 1);
        for (c = 0; c < DIM_MAX; c++)
            send_item(MODE_REFERENCE, 7'($urandom), 7'(c), 16'($urandom),
                      (c == 0) ? 24'h800000 : 24'($urandom), c == DIM_MAX - 1);

        for (i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].kind == STEP_CFG)
                set_dimensions(dir_tab[i].dims);
            else
                send_item(dir_tab[i].mode, dir_tab[i].row, dir_tab[i].col, dir_tab[i].mval,
                          dir_tab[i].vval, dir_tab[i].last, dir_tab[i].fixed, dir_tab[i].res);
        end

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       d = 8'd1;
                1:       d = 8'd0;
                2:       d = 8'd128;
                5:       d = 8'd255;
                9:       d = 8'd200;
                12:      d = 8'd16;
                15:      d = 8'd40;
                default: d = 8'($urandom_range(2, 12));
            endcase
            steady = (p >= 10 && p <= 13);
            run_phase(d);
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (residual_due.size() != 0)
            @(negedge clk);
        n = active_dims();
        repeat (n * n + 32) @(negedge clk);
        if (n_bad == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- matvec_max_abs_residual_top.f -----
design/mvmar_pkg.sv
design/mvmar_dp.sv
design/mvmar_ctrl.sv
design/matvec_max_abs_residual_top.sv
test/tb_matvec_max_abs_residual_top.sv
